### rtl/hds_pkg.sv
`timescale 1ns / 1ps

package hds_pkg;

  // Fixed field widths of the ports
  localparam int OUT_TEMP_W = 24;
  localparam int COORD_W    = 5;
  localparam int WEIGHT_W   = 16;
  localparam int HOT_IDX_W  = 5;
  localparam int GS_W       = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Fraction bits dropped after the weighted sum
  localparam int FRAC_DROP = 16;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_WEIGHT = 3'd0,
    REG_EDGE_WEIGHT   = 3'd1,
    REG_CENTRE_WEIGHT = 3'd2,
    REG_HOT_TEMP      = 3'd3,
    REG_HOT_FIRST     = 3'd4,
    REG_HOT_LAST      = 3'd5,
    REG_GRID_SIDE     = 3'd6
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [WEIGHT_W-1:0]   CORNER_WEIGHT_RST = 16'd4096;
  localparam logic [WEIGHT_W-1:0]   EDGE_WEIGHT_RST   = 16'd8192;
  localparam logic [WEIGHT_W-1:0]   CENTRE_WEIGHT_RST = 16'd16384;
  localparam logic [CFG_DATA_W-1:0] HOT_TEMP_RST      = 24'd25600;
  localparam logic [HOT_IDX_W-1:0]  HOT_FIRST_RST     = 5'd6;
  localparam logic [HOT_IDX_W-1:0]  HOT_LAST_RST      = 5'd7;
  localparam logic [GS_W-1:0]       GRID_SIDE_RST     = 6'd16;

  // Position of a produced cell in the window; value is its order within one beat
  typedef enum logic [1:0] {
    KIND_MID    = 2'd0,
    KIND_RIGHT  = 2'd1,
    KIND_BOTTOM = 2'd2,
    KIND_CORNER = 2'd3
  } hds_kind_e;

  // Side information of one result travelling down the arithmetic pipe
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               hot;
    logic               last;
    logic               done;
  } hds_ctrl_t;

endpackage

### rtl/heat_diffusion_stencil_3x3.sv
`timescale 1ns / 1ps
// Path: an accepted beat is held in the job registers, and its results are issued one after
// another through pipe stages p1 and p2 to the output register.
// Throughput: one input beat per cycle while the output is not stalled and each beat causes at
// most one result; a beat causing more results (up to 4, at row and frame ends) holds the input
// until all are issued, since the arithmetic pipe takes one result per cycle.
// Reset clears the configuration to its defaults, the counters and the line buffer valid bits.

module heat_diffusion_stencil_3x3 import hds_pkg::*; #(
  parameter int MAX_SIDE  = 32,
  parameter int TEMP_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OUT_TEMP_W-1:0] cell_temp_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OUT_TEMP_W-1:0] new_temp_o,
  output logic [COORD_W-1:0]    out_row_o,
  output logic [COORD_W-1:0]    out_col_o,
  output logic                  run_last_o,
  output logic                  frame_done_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DATA_W = (TEMP_BITS < OUT_TEMP_W) ? TEMP_BITS : OUT_TEMP_W;
  localparam int SUM_W  = DATA_W + 2;
  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int EXT_W  = IDX_W + HOT_IDX_W;

  // Configuration registers
  logic [WEIGHT_W-1:0]   corner_w_q, edge_w_q, centre_w_q;
  logic [CFG_DATA_W-1:0] hot_temp_q;
  logic [HOT_IDX_W-1:0]  hot_first_q, hot_last_q;
  logic [GS_W-1:0]       grid_side_q;
  logic                  cfg_we, side_we;

  // Raster position and line buffer
  logic [IDX_W-1:0]    row_q, row_d, col_q, col_d;
  logic [GS_W-1:0]     side_now, side_m1;
  logic [IDX_W-1:0]    side_last;
  logic [2*DATA_W-1:0] lbuf_mem [MAX_SIDE];
  logic [2*DATA_W-1:0] lbuf_rd_q;
  logic [MAX_SIDE-1:0] lbuf_vld_q;
  logic                lbuf_rd_vld_q;
  logic [DATA_W-1:0]   x_val, mid_val, top_val;

  // Window and pending job
  logic [DATA_W-1:0] win_q [3][3];
  logic [DATA_W-1:0] win_d [3][3];
  logic [DATA_W-1:0] jwin_q [3][3];
  logic [3:0]        res_mask;
  logic              job_vld_q;
  logic [3:0]        job_pend_q;
  logic [IDX_W-1:0]  job_row_q, job_col_q;
  logic              in_acc;

  // Issue of one result per cycle while the pipe is not held
  hds_kind_e         iss_kind;
  logic [3:0]        iss_rest;
  logic              iss_fire, iss_ready;
  logic [IDX_W-1:0]  iss_row, iss_col;
  logic              iss_hot;
  logic [DATA_W-1:0] cn0, cn1, cn2, cn3, ed0, ed1, ed2, ed3, ctr;
  logic [SUM_W-1:0]  corner_sum, edge_sum;
  hds_ctrl_t         iss_ctrl;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign side_we     = cfg_we && (cfg_index_i == REG_GRID_SIDE);

  // Register write decode; unknown indexes drop the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_w_q  <= CORNER_WEIGHT_RST;
      edge_w_q    <= EDGE_WEIGHT_RST;
      centre_w_q  <= CENTRE_WEIGHT_RST;
      hot_temp_q  <= HOT_TEMP_RST;
      hot_first_q <= HOT_FIRST_RST;
      hot_last_q  <= HOT_LAST_RST;
      grid_side_q <= GRID_SIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_CORNER_WEIGHT: corner_w_q  <= cfg_data_i[WEIGHT_W-1:0];
        REG_EDGE_WEIGHT:   edge_w_q    <= cfg_data_i[WEIGHT_W-1:0];
        REG_CENTRE_WEIGHT: centre_w_q  <= cfg_data_i[WEIGHT_W-1:0];
        REG_HOT_TEMP:      hot_temp_q  <= cfg_data_i;
        REG_HOT_FIRST:     hot_first_q <= cfg_data_i[HOT_IDX_W-1:0];
        REG_HOT_LAST:      hot_last_q  <= cfg_data_i[HOT_IDX_W-1:0];
        REG_GRID_SIDE:     grid_side_q <= cfg_data_i[GS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the grid side to the supported range
  always_comb begin
    if (grid_side_q < GS_W'(2)) begin
      side_now = GS_W'(2);
    end else if (grid_side_q > GS_W'(MAX_SIDE)) begin
      side_now = GS_W'(MAX_SIDE);
    end else begin
      side_now = grid_side_q;
    end
    side_m1   = side_now - GS_W'(1);
    side_last = side_m1[IDX_W-1:0];
  end

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = job_vld_q && !(iss_fire && (iss_rest == 4'b0000));

  // Advance the raster position; a grid side write restarts the frame
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (side_we) begin
      row_d = '0;
      col_d = '0;
    end else if (in_acc) begin
      if (col_q == side_last) begin
        col_d = '0;
        row_d = (row_q == side_last) ? '0 : row_q + IDX_W'(1);
      end else begin
        col_d = col_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Line buffer: each entry holds the two rows above; read ahead at the next column
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lbuf_mem[col_q] <= {mid_val, x_val};
    end
    lbuf_rd_q <= lbuf_mem[col_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lbuf_vld_q    <= '0;
      lbuf_rd_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        lbuf_vld_q[col_q] <= 1'b1;
      end
      lbuf_rd_vld_q <= lbuf_vld_q[col_d];
    end
  end

  // Column entering the window; entries never written read as zero
  always_comb begin
    x_val   = cell_temp_i[DATA_W-1:0];
    mid_val = lbuf_rd_vld_q ? lbuf_rd_q[DATA_W-1:0] : '0;
    top_val = (lbuf_rd_vld_q && (row_q >= IDX_W'(2))) ? lbuf_rd_q[2*DATA_W-1:DATA_W] : '0;
  end

  // Shift the window, clearing it at the start of a row
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (col_q == '0) begin
        win_d[i][0] = '0;
        win_d[i][1] = '0;
      end else begin
        win_d[i][0] = win_q[i][1];
        win_d[i][1] = win_q[i][2];
      end
    end
    win_d[0][2] = top_val;
    win_d[1][2] = mid_val;
    win_d[2][2] = x_val;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      win_q <= win_d;
    end
  end

  // Cells made computable by this beat, in delivery order
  always_comb begin
    res_mask[KIND_MID]    = (row_q != '0) && (col_q != '0);
    res_mask[KIND_RIGHT]  = (row_q != '0) && (col_q == side_last);
    res_mask[KIND_BOTTOM] = (row_q == side_last) && (col_q != '0);
    res_mask[KIND_CORNER] = (row_q == side_last) && (col_q == side_last);
  end

  // Hold the window snapshot until all its results are issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q  <= 1'b0;
      job_pend_q <= '0;
    end else if (in_acc) begin
      job_vld_q  <= |res_mask;
      job_pend_q <= res_mask;
    end else if (iss_fire) begin
      job_vld_q  <= |iss_rest;
      job_pend_q <= iss_rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      jwin_q    <= win_d;
      job_row_q <= row_q;
      job_col_q <= col_q;
    end
  end

  // Pick the next pending result
  always_comb begin
    if (job_pend_q[KIND_MID]) begin
      iss_kind = KIND_MID;
    end else if (job_pend_q[KIND_RIGHT]) begin
      iss_kind = KIND_RIGHT;
    end else if (job_pend_q[KIND_BOTTOM]) begin
      iss_kind = KIND_BOTTOM;
    end else begin
      iss_kind = KIND_CORNER;
    end
    iss_rest = job_pend_q & ~(4'b0001 << iss_kind);
    iss_fire = job_vld_q && iss_ready;
  end

  // Gather the neighbours of the chosen cell by class; off-window ones are zero
  always_comb begin
    cn0 = '0; cn1 = '0; cn2 = '0; cn3 = '0;
    ed0 = '0; ed1 = '0; ed2 = '0; ed3 = '0;
    unique case (iss_kind)
      KIND_MID: begin
        cn0 = jwin_q[0][0]; cn1 = jwin_q[0][2]; cn2 = jwin_q[2][0]; cn3 = jwin_q[2][2];
        ed0 = jwin_q[0][1]; ed1 = jwin_q[1][0]; ed2 = jwin_q[1][2]; ed3 = jwin_q[2][1];
        ctr = jwin_q[1][1];
        iss_row = job_row_q - IDX_W'(1);
        iss_col = job_col_q - IDX_W'(1);
      end
      KIND_RIGHT: begin
        cn0 = jwin_q[0][1]; cn1 = jwin_q[2][1];
        ed0 = jwin_q[0][2]; ed1 = jwin_q[2][2]; ed2 = jwin_q[1][1];
        ctr = jwin_q[1][2];
        iss_row = job_row_q - IDX_W'(1);
        iss_col = job_col_q;
      end
      KIND_BOTTOM: begin
        cn0 = jwin_q[1][0]; cn1 = jwin_q[1][2];
        ed0 = jwin_q[1][1]; ed1 = jwin_q[2][0]; ed2 = jwin_q[2][2];
        ctr = jwin_q[2][1];
        iss_row = job_row_q;
        iss_col = job_col_q - IDX_W'(1);
      end
      KIND_CORNER: begin
        cn0 = jwin_q[1][1];
        ed0 = jwin_q[1][2]; ed1 = jwin_q[2][1];
        ctr = jwin_q[2][2];
        iss_row = job_row_q;
        iss_col = job_col_q;
      end
    endcase
    corner_sum = SUM_W'(cn0) + SUM_W'(cn1) + SUM_W'(cn2) + SUM_W'(cn3);
    edge_sum   = SUM_W'(ed0) + SUM_W'(ed1) + SUM_W'(ed2) + SUM_W'(ed3);
  end

  // Hot square test on full-width coordinates; an empty square forces nothing
  always_comb begin
    iss_hot = (hot_first_q <= hot_last_q)
           && (EXT_W'(iss_row) >= EXT_W'(hot_first_q))
           && (EXT_W'(iss_row) <= EXT_W'(hot_last_q))
           && (EXT_W'(iss_col) >= EXT_W'(hot_first_q))
           && (EXT_W'(iss_col) <= EXT_W'(hot_last_q));
    iss_ctrl.row  = COORD_W'(iss_row);
    iss_ctrl.col  = COORD_W'(iss_col);
    iss_ctrl.hot  = iss_hot;
    iss_ctrl.last = (iss_rest == 4'b0000);
    iss_ctrl.done = (iss_kind == KIND_CORNER);
  end

  hds_pipe #(
    .TEMP_BITS (TEMP_BITS)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .iss_valid_i  (job_vld_q),
    .iss_ready_o  (iss_ready),
    .corner_sum_i (corner_sum),
    .edge_sum_i   (edge_sum),
    .centre_i     (ctr),
    .ctrl_i       (iss_ctrl),
    .corner_w_i   (corner_w_q),
    .edge_w_i     (edge_w_q),
    .centre_w_i   (centre_w_q),
    .hot_temp_i   (hot_temp_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .new_temp_o   (new_temp_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .run_last_o   (run_last_o),
    .frame_done_o (frame_done_o)
  );

endmodule

### rtl/hds_pipe.sv
`timescale 1ns / 1ps

module hds_pipe import hds_pkg::*; #(
  parameter int TEMP_BITS = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   iss_valid_i,
  output logic                                   iss_ready_o,
  input  logic [((TEMP_BITS < OUT_TEMP_W) ? TEMP_BITS : OUT_TEMP_W)+1:0] corner_sum_i,
  input  logic [((TEMP_BITS < OUT_TEMP_W) ? TEMP_BITS : OUT_TEMP_W)+1:0] edge_sum_i,
  input  logic [((TEMP_BITS < OUT_TEMP_W) ? TEMP_BITS : OUT_TEMP_W)-1:0] centre_i,
  input  hds_ctrl_t                              ctrl_i,
  input  logic [WEIGHT_W-1:0]                    corner_w_i,
  input  logic [WEIGHT_W-1:0]                    edge_w_i,
  input  logic [WEIGHT_W-1:0]                    centre_w_i,
  input  logic [CFG_DATA_W-1:0]                  hot_temp_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [OUT_TEMP_W-1:0]                  new_temp_o,
  output logic [COORD_W-1:0]                     out_row_o,
  output logic [COORD_W-1:0]                     out_col_o,
  output logic                                   run_last_o,
  output logic                                   frame_done_o
);

  localparam int DATA_W = (TEMP_BITS < OUT_TEMP_W) ? TEMP_BITS : OUT_TEMP_W;
  localparam int SUM_W  = DATA_W + 2;
  localparam int CP_W   = SUM_W + WEIGHT_W;
  localparam int MP_W   = DATA_W + WEIGHT_W;
  localparam int ACC_W  = DATA_W + 20;
  localparam int RND_W  = ACC_W - FRAC_DROP;
  localparam int SAT_A  = (RND_W > TEMP_BITS) ? RND_W : TEMP_BITS;
  localparam int SAT_W  = (SAT_A > OUT_TEMP_W) ? SAT_A : OUT_TEMP_W;
  localparam logic [SAT_W-1:0] TEMP_MAX  = {SAT_W{1'b1}} >> (SAT_W - TEMP_BITS);
  localparam logic [ACC_W-1:0] RND_HALF  = ACC_W'(1) << (FRAC_DROP - 1);

  logic              adv;
  logic              p1_vld_q, p2_vld_q, out_vld_q;
  logic [SUM_W-1:0]  p1_cs_q, p1_es_q;
  logic [DATA_W-1:0] p1_ctr_q;
  hds_ctrl_t         p1_ctrl_q, p2_ctrl_q;
  logic [CP_W-1:0]   p2_cp_q, p2_ep_q;
  logic [MP_W-1:0]   p2_mp_q;
  logic [ACC_W-1:0]  acc;
  logic [SAT_W-1:0]  rnd_ext, hot_ext, sat_val, hot_val;
  logic [OUT_TEMP_W-1:0] temp_d;
  logic [OUT_TEMP_W-1:0] temp_q;
  hds_ctrl_t         out_ctrl_q;

  // Advance the whole pipe unless the output beat is held
  assign adv         = !out_vld_q || !out_stall_i;
  assign iss_ready_o = adv;

  // Valid bits of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      p1_vld_q  <= iss_valid_i;
      p2_vld_q  <= p1_vld_q;
      out_vld_q <= p2_vld_q;
    end
  end

  // Capture the neighbourhood sums
  always_ff @(posedge clk_i) begin
    if (adv && iss_valid_i) begin
      p1_cs_q   <= corner_sum_i;
      p1_es_q   <= edge_sum_i;
      p1_ctr_q  <= centre_i;
      p1_ctrl_q <= ctrl_i;
    end
  end

  // Weight each class of neighbour
  always_ff @(posedge clk_i) begin
    if (adv && p1_vld_q) begin
      p2_cp_q   <= CP_W'(p1_cs_q) * CP_W'(corner_w_i);
      p2_ep_q   <= CP_W'(p1_es_q) * CP_W'(edge_w_i);
      p2_mp_q   <= MP_W'(p1_ctr_q) * MP_W'(centre_w_i);
      p2_ctrl_q <= p1_ctrl_q;
    end
  end

  // Add, round half up, saturate, then force the hot square
  always_comb begin
    acc     = ACC_W'(p2_cp_q) + ACC_W'(p2_ep_q) + ACC_W'(p2_mp_q) + RND_HALF;
    rnd_ext = SAT_W'(acc[ACC_W-1:FRAC_DROP]);
    sat_val = (rnd_ext > TEMP_MAX) ? TEMP_MAX : rnd_ext;
    hot_ext = SAT_W'(hot_temp_i);
    hot_val = (hot_ext > TEMP_MAX) ? TEMP_MAX : hot_ext;
    temp_d  = p2_ctrl_q.hot ? hot_val[OUT_TEMP_W-1:0] : sat_val[OUT_TEMP_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv && p2_vld_q) begin
      temp_q     <= temp_d;
      out_ctrl_q <= p2_ctrl_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign new_temp_o   = temp_q;
  assign out_row_o    = out_ctrl_q.row;
  assign out_col_o    = out_ctrl_q.col;
  assign run_last_o   = out_ctrl_q.last;
  assign frame_done_o = out_ctrl_q.done;

endmodule

### test/tb_heat_diffusion_stencil_3x3.sv
`timescale 1ns / 1ps

module tb_heat_diffusion_stencil_3x3;
  import hds_pkg::*;

  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_TEMPS = 380;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef enum logic {
    FEED_TEMP,
    FEED_REG
  } feed_kind_e;

  typedef struct packed {
    feed_kind_e            kind;
    logic                  drain;
    logic [OUT_TEMP_W-1:0] temp;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } feed_t;

  typedef struct packed {
    logic [OUT_TEMP_W-1:0] temp;
    logic [COORD_W-1:0]    row;
    logic [COORD_W-1:0]    col;
    logic                  last;
    logic                  done;
  } heat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [OUT_TEMP_W-1:0] cell_temp_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [OUT_TEMP_W-1:0] new_temp_o;
  logic [COORD_W-1:0]    out_row_o;
  logic [COORD_W-1:0]    out_col_o;
  logic                  run_last_o;
  logic                  frame_done_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  heat_diffusion_stencil_3x3 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cell_temp_i  (cell_temp_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .new_temp_o   (new_temp_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .run_last_o   (run_last_o),
    .frame_done_o (frame_done_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stencil state mirrored from the block
  logic [WEIGHT_W-1:0]   w_corner = CORNER_WEIGHT_RST;
  logic [WEIGHT_W-1:0]   w_edge   = EDGE_WEIGHT_RST;
  logic [WEIGHT_W-1:0]   w_centre = CENTRE_WEIGHT_RST;
  logic [OUT_TEMP_W-1:0] hot_temp = HOT_TEMP_RST;
  logic [HOT_IDX_W-1:0]  hot_lo   = HOT_FIRST_RST;
  logic [HOT_IDX_W-1:0]  hot_hi   = HOT_LAST_RST;
  logic [GS_W-1:0]       side_reg = GRID_SIDE_RST;
  logic [OUT_TEMP_W-1:0] older_q [32] = '{default: '0};
  logic [OUT_TEMP_W-1:0] prev_q  [32] = '{default: '0};
  logic [OUT_TEMP_W-1:0] win [3][3]   = '{default: '{default: '0}};
  int                    row_q = 0;
  int                    col_q = 0;

  feed_t pending [$];
  heat_t cells_due [$];
  int    exp_total    = 0;
  int    rx_count     = 0;
  int    fail_count   = 0;
  int    cycle_count  = 0;
  int    quiet_cycles = 0;
  int    gap_left     = 0;
  int    rx_hold      = 0;
  int    launch_count = 0;
  logic  feed_empty   = 1'b0;
  logic  in_hold, cfg_hold, next_in, next_cfg;
  feed_t front;

  function automatic int eff_side(input logic [GS_W-1:0] s);
    if (s < 2) return 2;
    if (s > 32) return 32;
    return int'(s);
  endfunction

  // Weighted 3x3 sum around window position (rs, cs), or the hot temperature
  function automatic heat_t next_cell_temp(input int rs, input int cs, input int r,
                                           input int c, input int side);
    heat_t               res;
    logic [47:0]         acc;
    logic [WEIGHT_W-1:0] w;
    int                  dr, dc, rr, cc;
    acc = '0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        rr = rs + dr;
        cc = cs + dc;
        if (rr >= 0 && rr <= 2 && cc >= 0 && cc <= 2) begin
          if (dr == 0 && dc == 0) w = w_centre;
          else if (dr != 0 && dc != 0) w = w_corner;
          else w = w_edge;
          acc = acc + win[rr][cc] * w;
        end
      end
    end
    acc = (acc + 48'd32768) >> FRAC_DROP;
    res.temp = (acc > 48'hFFFFFF) ? 24'hFFFFFF : acc[OUT_TEMP_W-1:0];
    if (hot_lo <= hot_hi && r >= hot_lo && r <= hot_hi && c >= hot_lo && c <= hot_hi)
      res.temp = hot_temp;
    res.row  = r[COORD_W-1:0];
    res.col  = c[COORD_W-1:0];
    res.last = 1'b0;
    res.done = (r == side - 1 && c == side - 1);
    return res;
  endfunction

  // Shift one accepted temperature into the line buffers and window, queue what it yields
  task automatic step_stencil(input logic [OUT_TEMP_W-1:0] x);
    int                    side, r, c, i;
    logic [OUT_TEMP_W-1:0] top, mid;
    heat_t                 batch [$];
    side = eff_side(side_reg);
    r = row_q;
    c = col_q;
    if (r >= side) r = 0;
    if (c >= side) c = 0;
    top = (r >= 2) ? older_q[c] : '0;
    mid = prev_q[c];
    older_q[c] = prev_q[c];
    prev_q[c] = x;
    for (i = 0; i < 3; i++) begin
      if (c == 0) begin
        win[i][0] = '0;
        win[i][1] = '0;
      end else begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = x;
    if (r >= 1 && c >= 1) batch.push_back(next_cell_temp(1, 1, r - 1, c - 1, side));
    if (r >= 1 && c == side - 1) batch.push_back(next_cell_temp(1, 2, r - 1, c, side));
    if (r == side - 1 && c >= 1) batch.push_back(next_cell_temp(2, 1, r, c - 1, side));
    if (r == side - 1 && c == side - 1) batch.push_back(next_cell_temp(2, 2, r, c, side));
    if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) cells_due.push_back(batch[k]);
    exp_total <= exp_total + batch.size();
    c++;
    if (c >= side) begin
      c = 0;
      r++;
      if (r >= side) r = 0;
    end
    row_q = r;
    col_q = c;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CORNER_WEIGHT: w_corner = data[WEIGHT_W-1:0];
      REG_EDGE_WEIGHT:   w_edge = data[WEIGHT_W-1:0];
      REG_CENTRE_WEIGHT: w_centre = data[WEIGHT_W-1:0];
      REG_HOT_TEMP:      hot_temp = data[OUT_TEMP_W-1:0];
      REG_HOT_FIRST:     hot_lo = data[HOT_IDX_W-1:0];
      REG_HOT_LAST:      hot_hi = data[HOT_IDX_W-1:0];
      REG_GRID_SIDE: begin
        side_reg = data[GS_W-1:0];
        row_q = 0;
        col_q = 0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Driver: present queued beats, hold them while stalled, drain before register writes and marked beats
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      cfg_valid_i  <= 1'b0;
      gap_left     <= 0;
      quiet_cycles <= 0;
      feed_empty   <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) step_stencil(cell_temp_i);
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (exp_total == rx_count && !in_valid_i && !cfg_valid_i)
        quiet_cycles <= (quiet_cycles < SETTLE) ? quiet_cycles + 1 : quiet_cycles;
      else
        quiet_cycles <= 0;
      in_hold  = in_valid_i && in_stall_o;
      cfg_hold = cfg_valid_i && !cfg_ready_o;
      if (!in_hold && !cfg_hold) begin
        next_in  = 1'b0;
        next_cfg = 1'b0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending.size() != 0) begin
          if ((pending[0].kind == FEED_TEMP && !pending[0].drain) || quiet_cycles >= SETTLE) begin
            front = pending.pop_front();
            if (front.kind == FEED_REG) begin
              cfg_index_i <= front.idx;
              cfg_data_i  <= front.data;
              next_cfg = 1'b1;
            end else begin
              cell_temp_i <= front.temp;
              next_in = 1'b1;
            end
            launch_count <= launch_count + 1;
            gap_left <= (launch_count % 80 < 20) ? 0 : $urandom_range(0, 5);
          end
        end
        in_valid_i  <= next_in;
        cfg_valid_i <= next_cfg;
      end
      feed_empty <= (pending.size() == 0);
    end
  end

  // Monitor: compare each result beat with the oldest expectation, stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_hold     <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected result, got temp %0h row %0d col %0d", $time,
                 new_temp_o, out_row_o, out_col_o);
        fail_count++;
      end else begin
        check_field("new_temp", 32'(new_temp_o), 32'(cells_due[0].temp));
        check_field("out_row", 32'(out_row_o), 32'(cells_due[0].row));
        check_field("out_col", 32'(out_col_o), 32'(cells_due[0].col));
        check_field("run_last", 32'(run_last_o), 32'(cells_due[0].last));
        check_field("frame_done", 32'(frame_done_o), 32'(cells_due[0].done));
        void'(cells_due.pop_front());
        rx_count <= rx_count + 1;
      end
      if (rx_count % 50 >= 12 && $urandom_range(0, 1)) begin
        rx_hold     <= $urandom_range(1, 5);
        out_stall_i <= 1'b1;
      end else begin
        rx_hold     <= (rx_count % 50 < 12) ? 0 : $urandom_range(0, 5);
        out_stall_i <= 1'b0;
      end
    end else if (rx_hold != 0) begin
      rx_hold     <= rx_hold - 1;
      out_stall_i <= (rx_hold > 1);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_temp(input logic [OUT_TEMP_W-1:0] temp, input logic drain);
    feed_t f;
    f = '0;
    f.kind  = FEED_TEMP;
    f.drain = drain;
    f.temp  = temp;
    pending.push_back(f);
  endtask

  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    feed_t f;
    f = '0;
    f.kind  = FEED_REG;
    f.drain = 1'b1;
    f.idx   = idx;
    f.data  = data;
    pending.push_back(f);
  endtask

  function automatic logic [OUT_TEMP_W-1:0] random_temp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return OUT_TEMP_W'($urandom_range(0, 16'hFFFF));
      default: return OUT_TEMP_W'($urandom & 24'hFFFFFF);
    endcase
  endfunction

  // Weight data: full range, diffusion-like up to cap, or an extreme; stray upper bits at times
  function automatic logic [CFG_DATA_W-1:0] pick_weight(input int style, input int cap);
    logic [CFG_DATA_W-1:0] d;
    case (style)
      0:       d = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
      1, 2:    d = CFG_DATA_W'($urandom_range(0, cap));
      default: d = $urandom_range(0, 1) ? 24'h00FFFF : 24'h0;
    endcase
    if ($urandom_range(0, 3) == 0) d = d | CFG_DATA_W'($urandom & 24'hFF0000);
    return d;
  endfunction

  initial begin
    int total, items, eff, style, side_code, i;
    logic [CFG_DATA_W-1:0] data;

    // Saturation: full weights on the smallest grid, upper data bits dropped
    queue_reg(REG_CORNER_WEIGHT, 24'hFFFFFF);
    queue_reg(REG_EDGE_WEIGHT, 24'h00FFFF);
    queue_reg(REG_CENTRE_WEIGHT, 24'h12FFFF);
    queue_reg(REG_GRID_SIDE, 24'd2);
    queue_temp(24'hFFFFFF, 1'b0);
    queue_temp(24'h000000, 1'b0);
    queue_temp(24'hFFFFFF, 1'b0);
    queue_temp(24'hFFFFFF, 1'b0);

    // Zero weights, side code zero acts as the minimum
    queue_reg(REG_CORNER_WEIGHT, 24'h0);
    queue_reg(REG_EDGE_WEIGHT, 24'h0);
    queue_reg(REG_CENTRE_WEIGHT, 24'h0);
    queue_reg(REG_GRID_SIDE, 24'hFFFFC0);
    queue_temp(24'h800000, 1'b0);
    queue_temp(24'hFFFFFF, 1'b0);
    queue_temp(24'h000001, 1'b0);
    queue_temp(24'h7FFFFF, 1'b0);

    // 3x3 grid with a hot centre cell; a write to the unused index must do nothing
    queue_reg(REG_NONE, 24'hABCDEF);
    queue_reg(REG_CORNER_WEIGHT, 24'd4096);
    queue_reg(REG_EDGE_WEIGHT, 24'd8192);
    queue_reg(REG_CENTRE_WEIGHT, 24'd16384);
    queue_reg(REG_HOT_TEMP, 24'hFFFFFF);
    queue_reg(REG_HOT_FIRST, 24'd1);
    queue_reg(REG_HOT_LAST, 24'd1);
    queue_reg(REG_GRID_SIDE, 24'd3);
    for (i = 0; i < 9; i++) queue_temp((i % 2) ? 24'hFFFFFF : 24'h123456, i == 4);

    // Empty hot square, side code one acts as the minimum
    queue_reg(REG_HOT_FIRST, 24'd2);
    queue_reg(REG_HOT_LAST, 24'd1);
    queue_reg(REG_GRID_SIDE, 24'd1);
    for (i = 0; i < 4; i++) queue_temp(random_temp(), 1'b0);

    // Random phases: mostly whole small frames, some partial frames and large sides
    total = 0;
    eff = 2;
    while (total < RANDOM_TEMPS) begin
      if ($urandom_range(0, 3) != 0) begin
        style = $urandom_range(0, 3);
        queue_reg(REG_CORNER_WEIGHT, pick_weight(style, 4096));
        queue_reg(REG_EDGE_WEIGHT, pick_weight(style, 8192));
        queue_reg(REG_CENTRE_WEIGHT, pick_weight(style, 32768));
      end
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 19))
          0:       side_code = $urandom_range(0, 1);
          1:       side_code = $urandom_range(33, 63);
          2:       side_code = $urandom_range(31, 32);
          default: side_code = $urandom_range(2, 6);
        endcase
        data = CFG_DATA_W'(side_code);
        if ($urandom_range(0, 1)) data = data | CFG_DATA_W'($urandom & 24'hFFFFC0);
        queue_reg(REG_GRID_SIDE, data);
        eff = eff_side(side_code[GS_W-1:0]);
      end
      if ($urandom_range(0, 1)) begin
        data = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, eff - 1));
        queue_reg(REG_HOT_FIRST, data | CFG_DATA_W'($urandom & 24'hFFFFE0));
        data = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, eff - 1));
        queue_reg(REG_HOT_LAST, data | CFG_DATA_W'($urandom & 24'hFFFFE0));
        queue_reg(REG_HOT_TEMP, random_temp());
      end
      if ($urandom_range(0, 15) == 0) queue_reg(REG_NONE, CFG_DATA_W'($urandom & 24'hFFFFFF));
      if (eff > 8) begin
        items = $urandom_range(40, 90);
      end else begin
        items = eff * eff * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) items = items + $urandom_range(1, eff * eff - 1);
      end
      for (i = 0; i < items; i++) queue_temp(random_temp(), $urandom_range(0, 39) == 0);
      total = total + items;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the feed to empty and every expected result to arrive
    while (!(feed_empty && !in_valid_i && !cfg_valid_i && exp_total == rx_count))
      @(posedge clk_i);
    repeat (4 * SETTLE) @(posedge clk_i);
    if (fail_count == 0 && cells_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
